@@ sv/frb_pkg.sv @@
// shared types, constants and sizes of the frame bitmap allocator
package frb_pkg;

	// store geometry
	localparam int NUM_FRAMES  = 32768;
	localparam int FRAME_BYTES = 4096;
	localparam int WORD_BITS   = 32;
	localparam int BIT_W       = 5;
	localparam int MAP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
	localparam int FRAME_CNT_W = $clog2(NUM_FRAMES + 1);
	localparam int POP_W       = BIT_W + 1;

	// payload widths
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 16;
	localparam int LIMIT_W = 16;

	// configuration port
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = LIMIT_W'(NUM_FRAMES);

	// request kinds
	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_RESERVE = 2'd3
	} req_type_t;

	// control of the shared word unit
	typedef struct packed {
		req_type_t        op;
		logic [BIT_W-1:0] lo_bit;
		logic [BIT_W-1:0] hi_bit;
	} word_ctl_t;

	// status coming back from the shared word unit
	typedef struct packed {
		logic [WORD_BITS-1:0] new_word;
		logic                 hit;
		logic [BIT_W-1:0]     bit_idx;
		logic [POP_W-1:0]     pop;
	} word_sts_t;

	// frame number limited to the size of the store
	function automatic logic [FRAME_CNT_W-1:0] clamp_frames(input logic [ADDR_W:0] f);
		if (f > (ADDR_W + 1)'(NUM_FRAMES))
			return FRAME_CNT_W'(NUM_FRAMES);
		else
			return f[FRAME_CNT_W-1:0];
	endfunction

endpackage

@@ sv/frb_req_if.sv @@
// request channel: valid/ready handshake with the request payload
interface frb_req_if import frb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ADDR_W-1:0] address;
	logic [ADDR_W-1:0] end_address;

	modport source (output valid, req_type, address, end_address, input ready);
	modport sink (input valid, req_type, address, end_address, output ready);
endinterface

@@ sv/frb_rsp_if.sv @@
// result channel: valid/ready handshake with the result payload
interface frb_rsp_if import frb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  frame_address;
	logic               out_of_memory;
	logic               changed;
	logic [COUNT_W-1:0] used_count;

	modport source (output valid, frame_address, out_of_memory, changed, used_count,
		input ready);
	modport sink (input valid, frame_address, out_of_memory, changed, used_count,
		output ready);
endinterface

@@ sv/frb_word_unit.sv @@
// shared word unit: masks a bitmap word, finds the first candidate bit, counts, updates
module frb_word_unit import frb_pkg::*; (
	input  logic [WORD_BITS-1:0] word,
	input  word_ctl_t            ctl,
	output word_sts_t            sts
);

	localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [BIT_W-1:0]     first_idx;

	// population count as a balanced adder tree
	function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) l1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
		for (int i = 0; i < 8; i++) l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
		for (int i = 0; i < 4; i++) l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
		for (int i = 0; i < 2; i++) l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
		return POP_W'(l4[0]) + POP_W'(l4[1]);
	endfunction

	// bits of this word that lie inside the run
	assign mask = (ALL_ONES << ctl.lo_bit) & (ALL_ONES >> (BIT_W'(WORD_BITS - 1) - ctl.hi_bit));

	// candidate bits for the request kind
	always_comb begin
		case (ctl.op)
			REQ_ALLOC:   cand = ~word & mask;
			REQ_FREE:    cand = word & mask;
			REQ_RESERVE: cand = ~word & mask;
			default:     cand = '0;
		endcase
	end

	// lowest candidate bit
	always_comb begin
		first_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i])
				first_idx = BIT_W'(i);
		end
	end

	// updated word
	always_comb begin
		case (ctl.op)
			REQ_ALLOC:   sts.new_word = cand[first_idx] ? (word | (WORD_BITS'(1) << first_idx))
			                                            : word;
			REQ_FREE:    sts.new_word = word & ~mask;
			REQ_RELEASE: sts.new_word = word & ~mask;
			REQ_RESERVE: sts.new_word = word | mask;
			default:     sts.new_word = word;
		endcase
	end

	assign sts.hit     = |cand;
	assign sts.bit_idx = first_idx;
	assign sts.pop     = popcount(cand);

endmodule

@@ sv/frame_bitmap_allocator_core.sv @@
// first-fit bitmap frame allocator: bitmap memory, word-walk sequencer and config port
// allocate reads bitmap words up to the first one with a free frame (at most up to frame_limit);
//   range requests and free read the words they touch; empty requests skip the walk
// throughput: one request walked at a time (the previous result may still wait on rsp); the walk reads one word a cycle
// reset: a pass writes all 1024 bitmap words to ones (every frame used) while req.ready
//   stays low; used count resets to 0 and frame_limit to 32768
module frame_bitmap_allocator_core import frb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	frb_req_if.sink           req,
	frb_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RESULT
	} state_t;

	state_t               state_q;
	logic [WORD_AW-1:0]   clr_word_q;
	req_type_t            op_q;
	logic [WORD_AW-1:0]   first_word_q;
	logic [WORD_AW-1:0]   last_word_q;
	logic [BIT_W-1:0]     first_bit_q;
	logic [BIT_W-1:0]     last_bit_q;
	logic [WORD_AW-1:0]   rd_word_q;
	logic                 rd_active_q;
	logic                 valid_s1;
	logic [WORD_AW-1:0]   word_s1;
	logic [WORD_BITS-1:0] rdata_s1;
	logic [COUNT_W-1:0]   used_q;
	logic [LIMIT_W-1:0]   frame_limit_q;
	logic [ADDR_W-1:0]    res_faddr_q;
	logic                 res_oom_q;
	logic                 res_chg_q;
	logic                 rsp_valid_q;
	logic [ADDR_W-1:0]    rsp_faddr_q;
	logic                 rsp_oom_q;
	logic                 rsp_chg_q;
	logic [COUNT_W-1:0]   rsp_used_q;

	logic [WORD_BITS-1:0] frame_map [MAP_WORDS];

	// request decode
	req_type_t            in_op;
	logic [FRAME_CNT_W-1:0] lim;
	logic [ADDR_W-1:0]    free_frame;
	logic [ADDR_W:0]      end_ceil;
	logic [FRAME_CNT_W-1:0] run_first;
	logic [FRAME_CNT_W-1:0] run_last;
	logic [FRAME_CNT_W-1:0] run_lastm1;
	logic                 run_ok;
	logic                 accept;

	// walk datapath
	word_ctl_t            unit_ctl;
	word_sts_t            unit_sts;
	logic                 walk_done;
	logic                 issue;
	logic [COUNT_W-1:0]   used_next;
	logic [COUNT_W:0]     used_sum;
	logic [FRAME_CNT_W-1:0] alloc_frame;
	logic                 cfg_wr;
	logic                 mem_we;
	logic [WORD_AW-1:0]   mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 rsp_load;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[APB_AW-1 -: CFG_IDX_W] == CFG_IDX_LIMIT)
	                ? APB_DW'(frame_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= LIMIT_RESET;
		end else if (cfg_wr && paddr[APB_AW-1 -: CFG_IDX_W] == CFG_IDX_LIMIT) begin
			frame_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// run of frames that the incoming request covers
	always_comb begin
		in_op      = req_type_t'(req.req_type);
		lim        = (frame_limit_q > LIMIT_W'(NUM_FRAMES)) ? FRAME_CNT_W'(NUM_FRAMES)
		                                                    : FRAME_CNT_W'(frame_limit_q);
		free_frame = req.address >> FRAME_SHIFT;
		end_ceil   = (ADDR_W + 1)'(req.end_address >> FRAME_SHIFT)
		           + (ADDR_W + 1)'(|req.end_address[FRAME_SHIFT-1:0]);
		case (in_op)
			REQ_ALLOC: begin
				run_first = '0;
				run_last  = lim;
				run_ok    = (lim != '0);
			end
			REQ_FREE: begin
				run_first = free_frame[FRAME_CNT_W-1:0];
				run_last  = free_frame[FRAME_CNT_W-1:0] + FRAME_CNT_W'(1);
				run_ok    = (free_frame < ADDR_W'(lim));
			end
			REQ_RELEASE: begin
				run_first = clamp_frames((ADDR_W + 1)'(free_frame));
				run_last  = clamp_frames((ADDR_W + 1)'(req.end_address >> FRAME_SHIFT));
				run_ok    = (req.end_address > req.address) && (run_first < run_last);
			end
			REQ_RESERVE: begin
				run_first = clamp_frames((ADDR_W + 1)'(free_frame));
				run_last  = clamp_frames(end_ceil);
				run_ok    = (req.end_address > req.address) && (run_first < run_last);
			end
			default: begin
				run_first = '0;
				run_last  = '0;
				run_ok    = 1'b0;
			end
		endcase
		run_lastm1 = run_last - FRAME_CNT_W'(1);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid & req.ready;

	// shared word unit on the word read back from the bitmap
	always_comb begin
		unit_ctl.op     = op_q;
		unit_ctl.lo_bit = (word_s1 == first_word_q) ? first_bit_q : '0;
		unit_ctl.hi_bit = (word_s1 == last_word_q) ? last_bit_q : BIT_W'(WORD_BITS - 1);
	end

	frb_word_unit u_word_unit (
		.word (rdata_s1),
		.ctl  (unit_ctl),
		.sts  (unit_sts)
	);

	// walk control and count update
	always_comb begin
		walk_done   = (state_q == ST_WALK) && valid_s1 &&
		              ((word_s1 == last_word_q) || (op_q == REQ_ALLOC && unit_sts.hit));
		issue       = (state_q == ST_WALK) && rd_active_q && !walk_done;
		alloc_frame = FRAME_CNT_W'({word_s1, unit_sts.bit_idx});
		used_sum    = '0;
		used_next   = used_q;
		case (op_q)
			REQ_ALLOC: begin
				used_sum = (COUNT_W + 1)'(used_q) + (COUNT_W + 1)'(unit_sts.hit);
			end
			REQ_RESERVE: begin
				used_sum = (COUNT_W + 1)'(used_q) + (COUNT_W + 1)'(unit_sts.pop);
			end
			default: begin
				used_sum = (COUNT_W + 1)'(used_q);
			end
		endcase
		if (op_q == REQ_FREE) begin
			if (unit_sts.hit && used_q != '0)
				used_next = used_q - COUNT_W'(1);
		end else if (used_sum[COUNT_W]) begin
			used_next = '1;
		end else begin
			used_next = used_sum[COUNT_W-1:0];
		end
	end

	// bitmap write port: clearing pass or write-back of the walked word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_s1;
		mem_wdata = unit_sts.new_word;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_word_q;
			mem_wdata = '1;
		end else if (state_q == ST_WALK && valid_s1) begin
			mem_we = 1'b1;
		end
	end

	// bitmap memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			frame_map[mem_waddr] <= mem_wdata;
		if (issue)
			rdata_s1 <= frame_map[rd_word_q];
	end

	// result register loads once the previous transaction has left
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp.ready);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_word_q   <= '0;
			op_q         <= REQ_ALLOC;
			first_word_q <= '0;
			last_word_q  <= '0;
			first_bit_q  <= '0;
			last_bit_q   <= '0;
			rd_word_q    <= '0;
			rd_active_q  <= 1'b0;
			valid_s1     <= 1'b0;
			word_s1      <= '0;
			used_q       <= '0;
			res_faddr_q  <= '0;
			res_oom_q    <= 1'b0;
			res_chg_q    <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_faddr_q  <= '0;
			rsp_oom_q    <= 1'b0;
			rsp_chg_q    <= 1'b0;
			rsp_used_q   <= '0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_word_q <= clr_word_q + WORD_AW'(1);
					if (clr_word_q == WORD_AW'(MAP_WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						op_q         <= in_op;
						first_word_q <= run_first[BIT_W +: WORD_AW];
						last_word_q  <= run_lastm1[BIT_W +: WORD_AW];
						first_bit_q  <= run_first[BIT_W-1:0];
						last_bit_q   <= run_lastm1[BIT_W-1:0];
						rd_word_q    <= run_first[BIT_W +: WORD_AW];
						rd_active_q  <= run_ok;
						valid_s1     <= 1'b0;
						res_faddr_q  <= '0;
						res_oom_q    <= (in_op == REQ_ALLOC);
						res_chg_q    <= 1'b0;
						state_q      <= run_ok ? ST_WALK : ST_RESULT;
					end
				end
				ST_WALK: begin
					if (valid_s1) begin
						used_q <= used_next;
						if (op_q == REQ_ALLOC && unit_sts.hit) begin
							res_faddr_q <= ADDR_W'(alloc_frame) << FRAME_SHIFT;
							res_oom_q   <= 1'b0;
						end
						if (op_q == REQ_FREE && unit_sts.hit)
							res_chg_q <= 1'b1;
					end
					if (issue) begin
						valid_s1  <= 1'b1;
						word_s1   <= rd_word_q;
						rd_word_q <= rd_word_q + WORD_AW'(1);
						if (rd_word_q == last_word_q)
							rd_active_q <= 1'b0;
					end else begin
						valid_s1 <= 1'b0;
					end
					if (walk_done) begin
						rd_active_q <= 1'b0;
						state_q     <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (rsp_load) begin
						rsp_faddr_q <= res_faddr_q;
						rsp_oom_q   <= res_oom_q;
						rsp_chg_q   <= res_chg_q;
						rsp_used_q  <= used_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result channel
	assign rsp.valid         = rsp_valid_q;
	assign rsp.frame_address = rsp_faddr_q;
	assign rsp.out_of_memory = rsp_oom_q;
	assign rsp.changed       = rsp_chg_q;
	assign rsp.used_count    = rsp_used_q;

endmodule
